FILE: rtl/fha_pkg.sv
`timescale 1ns / 1ps
// fha_pkg: shared widths, status and operation codes and hash constants
// for the FNV-hashed adjacency table. No dependencies.
package fha_pkg;

    localparam int NAME_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int TOTAL_W    = 5;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;
    localparam int RESULT_CAP = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUCKET_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LIST_FULL   = 2'd3;

    localparam logic [31:0] HASH_INIT = 32'h1234_5678 ^ 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

endpackage

FILE: rtl/fnv_hashed_adjacency_table.sv
`timescale 1ns / 1ps
// An item runs the hash states (high, then low key byte, up to a zero byte), the bucket
// reduction, the address state, read and check states per slot probed in the slot RAM,
// then the output. Lookups stream neighbors from the neighbor RAM, a read and an output
// state each, holding on a stall. One item is in flight at a time; the next is taken
// once the last word is queued. Reset: async active low; a clearing pass zeroes the
// slot RAM, one entry a cycle, with s_tready low. Depends on fha_pkg, fha_ram.
module fnv_hashed_adjacency_table #(
    parameter int BUCKETS       = 256,
    parameter int SLOTS         = 4,
    parameter int MAX_NEIGHBORS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fha_pkg::IN_DATA_W-1:0]   s_tdata,   // key_name, neighbor_name
    input  logic                            s_tuser,   // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fha_pkg::OUT_DATA_W-1:0]  m_tdata,   // neighbor_out, neighbor_total, pad
    output logic [fha_pkg::STATUS_W-1:0]    m_tuser,   // status
    output logic                            m_tlast
);

    import fha_pkg::*;

    localparam int SLOT_TOTAL = BUCKETS * SLOTS;
    localparam int SLOT_AW    = $clog2(SLOT_TOTAL);
    localparam int NB_DEPTH   = SLOT_TOTAL * MAX_NEIGHBORS;
    localparam int NB_AW      = $clog2(NB_DEPTH);
    localparam int BW         = $clog2(BUCKETS);
    localparam int CW         = $clog2(MAX_NEIGHBORS + 1);
    localparam int SCW        = $clog2(SLOTS + 1);
    localparam int NCAP       = (MAX_NEIGHBORS < RESULT_CAP) ? MAX_NEIGHBORS : RESULT_CAP;
    localparam int IW         = $clog2(NCAP + 1);
    localparam int SE_W       = 1 + CW + NAME_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH_HI,
        S_HASH_LO,
        S_MOD,
        S_BASE,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_RES,
        S_NB_RD,
        S_NB_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_AW-1:0]    clr_reg, clr_next;
    logic                  op_reg, op_next;
    logic [NAME_W-1:0]     key_reg, key_next;
    logic [NAME_W-1:0]     nbin_reg, nbin_next;
    logic [31:0]           h_reg, h_next;
    logic [1:0]            mcnt_reg, mcnt_next;
    logic [BW-1:0]         rem_reg, rem_next;
    logic [SLOT_AW-1:0]    saddr_reg, saddr_next;
    logic [SCW-1:0]        scnt_reg, scnt_next;
    logic [NB_AW-1:0]      nbase_reg, nbase_next;
    logic [IW-1:0]         nidx_reg, nidx_next;
    logic [IW-1:0]         ncnt_reg, ncnt_next;
    logic [CW-1:0]         total_reg, total_next;
    logic [STATUS_W-1:0]   rstat_reg, rstat_next;
    logic                  mval_reg, mval_next;
    logic [STATUS_W-1:0]   mstat_reg, mstat_next;
    logic [NAME_W-1:0]     mnb_reg, mnb_next;
    logic [TOTAL_W-1:0]    mtot_reg, mtot_next;
    logic                  mlast_reg, mlast_next;

    logic [31:0]           mul_in;
    logic [31:0]           mul_out;
    logic [BW:0]           rem_step;
    logic [BW-1:0]         rem_calc;
    logic                  out_free;
    logic                  accept;

    logic                  slot_wr_en;
    logic [SLOT_AW-1:0]    slot_wr_addr;
    logic [SE_W-1:0]       slot_wr_data;
    logic                  slot_rd_en;
    logic [SE_W-1:0]       slot_rd_data;
    logic                  nb_wr_en;
    logic [NB_AW-1:0]      nb_wr_addr;
    logic                  nb_rd_en;
    logic [NB_AW-1:0]      nb_rd_addr;
    logic [NAME_W-1:0]     nb_rd_data;

    logic                  ent_valid;
    logic [CW-1:0]         ent_cnt;
    logic [NAME_W-1:0]     ent_key;
    logic [CW-1:0]         cnt_eff;
    logic                  last_slot;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mval_reg || m_tready;

    assign m_tvalid = mval_reg;
    assign m_tuser  = mstat_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {{(OUT_DATA_W - NAME_W - TOTAL_W){1'b0}}, mtot_reg, mnb_reg};

    assign {ent_valid, ent_cnt, ent_key} = slot_rd_data;
    assign cnt_eff   = ent_valid ? ent_cnt : '0;
    assign last_slot = (scnt_reg == SCW'(SLOTS - 1));

    assign mul_in  = h_reg ^ {24'd0, (state_reg == S_HASH_HI) ? key_reg[15:8] : key_reg[7:0]};
    assign mul_out = mul_in * FNV_PRIME;

    assign nb_rd_addr = nbase_reg + NB_AW'(nidx_reg);
    assign nb_wr_addr = nbase_reg + NB_AW'(cnt_eff);

    // eight bits of the hash per cycle, most significant first
    always_comb
    begin
        rem_calc = rem_reg;
        rem_step = '0;
        for (int i = 0; i < 8; i++)
        begin
            rem_step = {rem_calc, h_reg[31 - i]};
            if (rem_step >= (BW + 1)'(BUCKETS))
            begin
                rem_step = rem_step - (BW + 1)'(BUCKETS);
            end
            rem_calc = rem_step[BW-1:0];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        nbin_next    = nbin_reg;
        h_next       = h_reg;
        mcnt_next    = mcnt_reg;
        rem_next     = rem_reg;
        saddr_next   = saddr_reg;
        scnt_next    = scnt_reg;
        nbase_next   = nbase_reg;
        nidx_next    = nidx_reg;
        ncnt_next    = ncnt_reg;
        total_next   = total_reg;
        rstat_next   = rstat_reg;
        mval_next    = mval_reg && !m_tready;
        mstat_next   = mstat_reg;
        mnb_next     = mnb_reg;
        mtot_next    = mtot_reg;
        mlast_next   = mlast_reg;
        slot_wr_en   = 1'b0;
        slot_wr_addr = saddr_reg;
        slot_wr_data = {1'b1, cnt_eff + CW'(1), key_reg};
        slot_rd_en   = 1'b0;
        nb_wr_en     = 1'b0;
        nb_rd_en     = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                slot_wr_en   = 1'b1;
                slot_wr_addr = clr_reg;
                slot_wr_data = '0;
                clr_next     = clr_reg + SLOT_AW'(1);
                if (clr_reg == SLOT_AW'(SLOT_TOTAL - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = s_tuser;
                    key_next   = s_tdata[NAME_W-1:0];
                    nbin_next  = s_tdata[2*NAME_W-1:NAME_W];
                    h_next     = HASH_INIT;
                    mcnt_next  = '0;
                    rem_next   = '0;
                    scnt_next  = '0;
                    nidx_next  = '0;
                    state_next = (s_tdata[15:8] != 8'd0) ? S_HASH_HI : S_MOD;
                end
            end
            S_HASH_HI:
            begin
                h_next     = mul_out;
                state_next = (key_reg[7:0] != 8'd0) ? S_HASH_LO : S_MOD;
            end
            S_HASH_LO:
            begin
                h_next     = mul_out;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                rem_next  = rem_calc;
                h_next    = {h_reg[23:0], 8'd0};
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3)
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                saddr_next = SLOT_AW'(rem_reg) * SLOT_AW'(SLOTS);
                state_next = S_SLOT_RD;
            end
            S_SLOT_RD:
            begin
                slot_rd_en = 1'b1;
                nbase_next = NB_AW'(saddr_reg) * NB_AW'(MAX_NEIGHBORS);
                state_next = S_SLOT_CHK;
            end
            S_SLOT_CHK:
            begin
                if (op_reg == OP_INSERT)
                begin
                    priority if (!ent_valid || ent_key == key_reg)
                    begin
                        state_next = S_RES;
                        if (cnt_eff >= CW'(MAX_NEIGHBORS))
                        begin
                            rstat_next = ST_LIST_FULL;
                            total_next = cnt_eff;
                        end
                        else
                        begin
                            slot_wr_en = 1'b1;
                            nb_wr_en   = 1'b1;
                            rstat_next = ST_OK;
                            total_next = cnt_eff + CW'(1);
                        end
                    end
                    else if (last_slot)
                    begin
                        rstat_next = ST_BUCKET_FULL;
                        total_next = '0;
                        state_next = S_RES;
                    end
                    else
                    begin
                        saddr_next = saddr_reg + SLOT_AW'(1);
                        scnt_next  = scnt_reg + SCW'(1);
                        state_next = S_SLOT_RD;
                    end
                end
                else
                begin
                    priority if (!ent_valid || (last_slot && ent_key != key_reg))
                    begin
                        rstat_next = ST_NOT_FOUND;
                        total_next = '0;
                        state_next = S_RES;
                    end
                    else if (ent_key == key_reg)
                    begin
                        total_next = ent_cnt;
                        ncnt_next  = (ent_cnt >= CW'(NCAP)) ? IW'(NCAP) : IW'(ent_cnt);
                        if (ent_cnt == '0)
                        begin
                            rstat_next = ST_OK;
                            state_next = S_RES;
                        end
                        else
                        begin
                            state_next = S_NB_RD;
                        end
                    end
                    else
                    begin
                        saddr_next = saddr_reg + SLOT_AW'(1);
                        scnt_next  = scnt_reg + SCW'(1);
                        state_next = S_SLOT_RD;
                    end
                end
            end
            S_RES:
            begin
                if (out_free)
                begin
                    mval_next  = 1'b1;
                    mstat_next = rstat_reg;
                    mnb_next   = '0;
                    mtot_next  = TOTAL_W'(total_reg);
                    mlast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_NB_RD:
            begin
                nb_rd_en   = 1'b1;
                state_next = S_NB_OUT;
            end
            S_NB_OUT:
            begin
                if (out_free)
                begin
                    mval_next  = 1'b1;
                    mstat_next = ST_OK;
                    mnb_next   = nb_rd_data;
                    mtot_next  = TOTAL_W'(total_reg);
                    mlast_next = (nidx_reg + IW'(1) == ncnt_reg);
                    nidx_next  = nidx_reg + IW'(1);
                    state_next = (nidx_reg + IW'(1) == ncnt_reg) ? S_IDLE : S_NB_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            op_reg    <= OP_INSERT;
            key_reg   <= '0;
            nbin_reg  <= '0;
            h_reg     <= '0;
            mcnt_reg  <= '0;
            rem_reg   <= '0;
            saddr_reg <= '0;
            scnt_reg  <= '0;
            nbase_reg <= '0;
            nidx_reg  <= '0;
            ncnt_reg  <= '0;
            total_reg <= '0;
            rstat_reg <= ST_OK;
            mval_reg  <= 1'b0;
            mstat_reg <= ST_OK;
            mnb_reg   <= '0;
            mtot_reg  <= '0;
            mlast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            op_reg    <= op_next;
            key_reg   <= key_next;
            nbin_reg  <= nbin_next;
            h_reg     <= h_next;
            mcnt_reg  <= mcnt_next;
            rem_reg   <= rem_next;
            saddr_reg <= saddr_next;
            scnt_reg  <= scnt_next;
            nbase_reg <= nbase_next;
            nidx_reg  <= nidx_next;
            ncnt_reg  <= ncnt_next;
            total_reg <= total_next;
            rstat_reg <= rstat_next;
            mval_reg  <= mval_next;
            mstat_reg <= mstat_next;
            mnb_reg   <= mnb_next;
            mtot_reg  <= mtot_next;
            mlast_reg <= mlast_next;
        end
    end

    // slot entry: {valid, neighbor count, key}
    fha_ram #(
        .WIDTH (SE_W),
        .DEPTH (SLOT_TOTAL)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (slot_rd_en),
        .rd_addr (saddr_reg),
        .rd_data (slot_rd_data)
    );

    fha_ram #(
        .WIDTH (NAME_W),
        .DEPTH (NB_DEPTH)
    ) u_nb_ram (
        .clk     (clk),
        .wr_en   (nb_wr_en),
        .wr_addr (nb_wr_addr),
        .wr_data (nbin_reg),
        .rd_en   (nb_rd_en),
        .rd_addr (nb_rd_addr),
        .rd_data (nb_rd_data)
    );

endmodule

FILE: rtl/fha_ram.sv
`timescale 1ns / 1ps
// fha_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
module fha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/fha_checker.sv
`timescale 1ns / 1ps
// fha_checker: port-level assertions for the FNV-hashed adjacency table,
// bound to the top level. Depends on fha_pkg.
module fha_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [fha_pkg::IN_DATA_W-1:0]   s_tdata,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fha_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [fha_pkg::STATUS_W-1:0]    m_tuser,
    input logic                            m_tlast
);

    import fha_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while an item is in work");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tlast && m_tdata[15:0] == 16'd0)
        else $error("error status word not single and empty");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_NOT_FOUND || m_tuser == ST_BUCKET_FULL)
            |-> m_tdata[20:16] == 5'd0)
        else $error("nonzero total on a miss or full bucket");

endmodule

bind fnv_hashed_adjacency_table fha_checker u_fha_checker (.*);
